[src/azcs_pkg.sv]
// ----------------------------------------------------------------------------
// azcs_pkg
// Shared types, widths and constants for the auto-zero current sense block.
// ----------------------------------------------------------------------------
package azcs_pkg;

  localparam int unsigned RAW_W   = 16;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned OUT_W   = 24;
  localparam int unsigned FRAC_W  = 16;  // Q16.16 scales

  localparam int unsigned RAW_MAX_DEF  = 4095;
  localparam int unsigned ZERO_L2_DEF  = 6;

  localparam logic [SCALE_W-1:0] CUR_SCALE_RST  = 32'd52429;
  localparam logic [SCALE_W-1:0] VBUS_SCALE_RST = 32'd1048576;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURRENT_SCALE = 1'b0,
    CFG_VBUS_SCALE    = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CONVERTED  = 3'd0,
    ST_CAL_SAMPLE = 3'd1,
    ST_CAL_DONE   = 3'd2,
    ST_REJECTED   = 3'd3,
    ST_RESTARTED  = 3'd4
  } status_t;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

endpackage

[src/azcs_if.sv]
// ----------------------------------------------------------------------------
// azcs channel interfaces
// Valid/ready channels for sample set items and result items.
// ----------------------------------------------------------------------------
interface azcs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [azcs_pkg::RAW_W-1:0]    cur_b_cnt;
  logic [azcs_pkg::RAW_W-1:0]    cur_a_cnt;
  logic [azcs_pkg::RAW_W-1:0]    vbus_cnt;
  logic [azcs_pkg::TAG_W-1:0]    capture_tag;

  modport source (output valid, req_type, cur_b_cnt, cur_a_cnt, vbus_cnt,
                  capture_tag, input ready);
  modport sink (input valid, req_type, cur_b_cnt, cur_a_cnt, vbus_cnt,
                capture_tag, output ready);
endinterface

interface azcs_out_if;
  logic                                 valid;
  logic                                 ready;
  azcs_pkg::status_t                    status;
  logic signed [azcs_pkg::OUT_W-1:0]    current_b_ma;
  logic signed [azcs_pkg::OUT_W-1:0]    current_a_ma;
  logic [azcs_pkg::OUT_W-1:0]           vbus_mv;
  logic [azcs_pkg::TAG_W-1:0]           tag_out;

  modport source (output valid, status, current_b_ma, current_a_ma, vbus_mv, tag_out,
                  input ready);
  modport sink (input valid, status, current_b_ma, current_a_ma, vbus_mv, tag_out,
                output ready);
endinterface

[src/azcs_cur_sat.sv]
// ----------------------------------------------------------------------------
// azcs_cur_sat
// Rounds a current product magnitude half away from zero, applies the sign
// and saturates to signed 24 bits.
// ----------------------------------------------------------------------------
module azcs_cur_sat #(
  parameter int unsigned ZERO_SAMPLES_LOG2 = azcs_pkg::ZERO_L2_DEF
) (
  input  logic                                   neg,
  input  logic [azcs_pkg::RAW_W+ZERO_SAMPLES_LOG2+azcs_pkg::SCALE_W-1:0] prod,
  output logic signed [azcs_pkg::OUT_W-1:0]      value
);

  localparam int unsigned PROD_W = azcs_pkg::RAW_W + ZERO_SAMPLES_LOG2 + azcs_pkg::SCALE_W;
  localparam int unsigned SHIFT  = azcs_pkg::FRAC_W + ZERO_SAMPLES_LOG2;
  localparam int unsigned RND_W  = PROD_W + 1 - SHIFT;

  localparam logic [PROD_W:0]  HALF    = (PROD_W+1)'(1) << (SHIFT - 1);
  localparam logic [RND_W-1:0] POS_MAX = RND_W'(2**(azcs_pkg::OUT_W-1) - 1);
  localparam logic [RND_W-1:0] NEG_MAX = RND_W'(2**(azcs_pkg::OUT_W-1));

  logic [PROD_W:0]  rnd_sum;
  logic [RND_W-1:0] mag;

  assign rnd_sum = (PROD_W+1)'(prod) + HALF;
  assign mag     = rnd_sum[PROD_W:SHIFT];

  always_comb begin
    if (neg) begin
      if (mag > NEG_MAX) begin
        value = -$signed(NEG_MAX[azcs_pkg::OUT_W-1:0]);
      end else begin
        value = $signed(-mag[azcs_pkg::OUT_W-1:0]);
      end
    end else begin
      if (mag > POS_MAX) begin
        value = $signed(POS_MAX[azcs_pkg::OUT_W-1:0]);
      end else begin
        value = $signed(mag[azcs_pkg::OUT_W-1:0]);
      end
    end
  end

endmodule

[src/auto_zero_current_sense.sv]
// ----------------------------------------------------------------------------
// auto_zero_current_sense
// Learns phase-current zero offsets, then scales current and bus voltage.
// ----------------------------------------------------------------------------
// Items arrive on in_ch (valid/ready): a restart request or a sample set of
// two phase-current counts, a bus-voltage count and a capture tag. Each item
// gives exactly one result on out_ch, in order, carrying the tag back.
// After reset or a restart the first 2^ZERO_SAMPLES_LOG2 good current pairs
// are summed as zero offsets; later sample sets are converted to mA and mV.
// The user must write scales on the cfg_ port only while no item is in flight;
// the block itself does not enforce this. Each item passes the input, product
// and result registers in that order before out_ch.valid rises for it.
// Throughput: one item per cycle unless out_ch stalls; the offset sums are
// updated in the first stage so each item sees the last. The two
// (16+ZERO_SAMPLES_LOG2)x32 current multipliers (22x32 by default) and the 16x32 bus
// multiplier sit in that first stage; rounding and saturation sit in the second.
// Reset clears the pipeline, the offset sums and the calibration count and
// loads the default scales, so calibration starts again.
// A stalled receiver holds the result register; up to three items stay in
// the pipe and in_ch.ready drops once all stages are full.
// ----------------------------------------------------------------------------
module auto_zero_current_sense #(
  parameter int unsigned RAW_MAX           = azcs_pkg::RAW_MAX_DEF,
  parameter int unsigned ZERO_SAMPLES_LOG2 = azcs_pkg::ZERO_L2_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  azcs_in_if.sink                           in_ch,
  azcs_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [azcs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [azcs_pkg::SCALE_W-1:0]      cfg_wdata
);

  localparam int unsigned RAW_W  = azcs_pkg::RAW_W;
  localparam int unsigned SUM_W  = RAW_W + ZERO_SAMPLES_LOG2;
  localparam int unsigned PROD_W = SUM_W + azcs_pkg::SCALE_W;
  localparam int unsigned VPRD_W = RAW_W + azcs_pkg::SCALE_W;
  localparam int unsigned CNT_W  = ZERO_SAMPLES_LOG2 + 1;
  localparam int unsigned OUT_W  = azcs_pkg::OUT_W;
  localparam int unsigned FRAC_W = azcs_pkg::FRAC_W;

  localparam logic [RAW_W-1:0] RAW_LIMIT = RAW_W'(RAW_MAX);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(2**ZERO_SAMPLES_LOG2);
  localparam logic [VPRD_W:0]  V_HALF    = (VPRD_W+1)'(1) << (FRAC_W - 1);

  // configuration
  logic [azcs_pkg::SCALE_W-1:0] cur_scale_r;
  logic [azcs_pkg::SCALE_W-1:0] vbus_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_scale_r  <= azcs_pkg::CUR_SCALE_RST;
      vbus_scale_r <= azcs_pkg::VBUS_SCALE_RST;
    end else if (cfg_we) begin
      unique case (azcs_pkg::cfg_idx_t'(cfg_idx))
        azcs_pkg::CFG_CURRENT_SCALE: cur_scale_r  <= cfg_wdata;
        azcs_pkg::CFG_VBUS_SCALE:    vbus_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_v_r, s2_v_r, out_v_r;
  logic s1_v_nxt, s2_v_nxt, out_v_nxt;
  logic out_free, s2_free, s1_free;
  logic in_acc, s1_adv, s2_adv;

  assign out_free = !out_v_r || out_ch.ready;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ch.ready = s1_free;
  assign in_acc   = in_ch.valid && s1_free;
  assign s1_adv   = s1_v_r && s2_free;
  assign s2_adv   = s2_v_r && out_free;

  assign s1_v_nxt  = s1_free  ? in_ch.valid : s1_v_r;
  assign s2_v_nxt  = s2_free  ? s1_v_r      : s2_v_r;
  assign out_v_nxt = out_free ? s2_v_r      : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // stage 1: input register
  logic             s1_req_r;
  logic [RAW_W-1:0] s1_b_r, s1_a_r, s1_v_raw_r;
  logic [azcs_pkg::TAG_W-1:0] s1_tag_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r   <= in_ch.req_type;
      s1_b_r     <= in_ch.cur_b_cnt;
      s1_a_r     <= in_ch.cur_a_cnt;
      s1_v_raw_r <= in_ch.vbus_cnt;
      s1_tag_r   <= in_ch.capture_tag;
    end
  end

  // calibration state
  logic [SUM_W-1:0] sum_b_r, sum_a_r, sum_b_nxt, sum_a_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic             zero_done_r, zero_done_nxt;
  azcs_pkg::status_t s1_status;
  logic cur_bad, v_bad, scale_zero;

  assign cur_bad    = (s1_b_r > RAW_LIMIT) || (s1_a_r > RAW_LIMIT);
  assign v_bad      = s1_v_raw_r > RAW_LIMIT;
  assign scale_zero = cur_scale_r == '0;
  assign cnt_inc    = cnt_r + 1'b1;

  always_comb begin
    s1_status     = azcs_pkg::ST_REJECTED;
    sum_b_nxt     = sum_b_r;
    sum_a_nxt     = sum_a_r;
    cnt_nxt       = cnt_r;
    zero_done_nxt = zero_done_r;
    if (s1_req_r == azcs_pkg::REQ_RESTART) begin
      s1_status     = azcs_pkg::ST_RESTARTED;
      sum_b_nxt     = '0;
      sum_a_nxt     = '0;
      cnt_nxt       = '0;
      zero_done_nxt = 1'b0;
    end else if (!zero_done_r) begin
      if (!(cur_bad || scale_zero)) begin
        sum_b_nxt = sum_b_r + SUM_W'(s1_b_r);
        sum_a_nxt = sum_a_r + SUM_W'(s1_a_r);
        cnt_nxt   = cnt_inc;
        if (cnt_inc == CNT_FULL) begin
          zero_done_nxt = 1'b1;
          s1_status     = azcs_pkg::ST_CAL_DONE;
        end else begin
          s1_status = azcs_pkg::ST_CAL_SAMPLE;
        end
      end
    end else if (!(cur_bad || v_bad || scale_zero)) begin
      s1_status = azcs_pkg::ST_CONVERTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_b_r     <= '0;
      sum_a_r     <= '0;
      cnt_r       <= '0;
      zero_done_r <= 1'b0;
    end else if (s1_adv) begin
      sum_b_r     <= sum_b_nxt;
      sum_a_r     <= sum_a_nxt;
      cnt_r       <= cnt_nxt;
      zero_done_r <= zero_done_nxt;
    end
  end

  // offset removal and multiply; the offset carries ZERO_SAMPLES_LOG2 fraction bits
  logic [SUM_W-1:0] lift_b, lift_a, mag_b, mag_a;
  logic             neg_b, neg_a;

  assign lift_b = SUM_W'(s1_b_r) << ZERO_SAMPLES_LOG2;
  assign lift_a = SUM_W'(s1_a_r) << ZERO_SAMPLES_LOG2;
  assign neg_b  = lift_b < sum_b_r;
  assign neg_a  = lift_a < sum_a_r;
  assign mag_b  = neg_b ? (sum_b_r - lift_b) : (lift_b - sum_b_r);
  assign mag_a  = neg_a ? (sum_a_r - lift_a) : (lift_a - sum_a_r);

  // stage 2: product register
  logic [PROD_W-1:0] s2_prod_b_r, s2_prod_a_r;
  logic [VPRD_W-1:0] s2_prod_v_r;
  logic              s2_neg_b_r, s2_neg_a_r;
  azcs_pkg::status_t s2_status_r;
  logic [azcs_pkg::TAG_W-1:0] s2_tag_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_prod_b_r <= PROD_W'(mag_b) * PROD_W'(cur_scale_r);
      s2_prod_a_r <= PROD_W'(mag_a) * PROD_W'(cur_scale_r);
      s2_prod_v_r <= VPRD_W'(s1_v_raw_r) * VPRD_W'(vbus_scale_r);
      s2_neg_b_r  <= neg_b;
      s2_neg_a_r  <= neg_a;
      s2_status_r <= s1_status;
      s2_tag_r    <= s1_tag_r;
    end
  end

  logic signed [OUT_W-1:0] ma_b, ma_a;
  logic [VPRD_W:0]         v_rnd;
  logic [VPRD_W-FRAC_W:0]  v_mag;
  logic [OUT_W-1:0]        mv;

  azcs_cur_sat #(.ZERO_SAMPLES_LOG2(ZERO_SAMPLES_LOG2)) u_sat_b (
    .neg   (s2_neg_b_r),
    .prod  (s2_prod_b_r),
    .value (ma_b)
  );

  azcs_cur_sat #(.ZERO_SAMPLES_LOG2(ZERO_SAMPLES_LOG2)) u_sat_a (
    .neg   (s2_neg_a_r),
    .prod  (s2_prod_a_r),
    .value (ma_a)
  );

  // bus voltage: round half up, clamp to full scale
  assign v_rnd = (VPRD_W+1)'(s2_prod_v_r) + V_HALF;
  assign v_mag = v_rnd[VPRD_W:FRAC_W];
  assign mv    = (v_mag[VPRD_W-FRAC_W:OUT_W] != '0) ? '1 : v_mag[OUT_W-1:0];

  // result register
  azcs_pkg::status_t       out_status_r;
  logic signed [OUT_W-1:0] out_b_r, out_a_r;
  logic [OUT_W-1:0]        out_mv_r;
  logic [azcs_pkg::TAG_W-1:0] out_tag_r;
  logic                    conv;

  assign conv = s2_status_r == azcs_pkg::ST_CONVERTED;

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_status_r <= s2_status_r;
      out_b_r      <= conv ? ma_b : '0;
      out_a_r      <= conv ? ma_a : '0;
      out_mv_r     <= conv ? mv   : '0;
      out_tag_r    <= s2_tag_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.current_b_ma = out_b_r;
  assign out_ch.current_a_ma = out_a_r;
  assign out_ch.vbus_mv      = out_mv_r;
  assign out_ch.tag_out      = out_tag_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("calibration count past sample total");

  a_done_full: assert property (@(posedge clk) disable iff (!rst_n)
    zero_done_r |-> cnt_r == CNT_FULL)
    else $error("calibration done before all samples taken");

  a_restart_clr: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_req_r == azcs_pkg::REQ_RESTART |=> cnt_r == '0 && !zero_done_r
      && sum_b_r == '0 && sum_a_r == '0)
    else $error("restart did not clear calibration state");

  a_zero_unless_conv: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_status_r != azcs_pkg::ST_CONVERTED |->
      out_b_r == '0 && out_a_r == '0 && out_mv_r == '0)
    else $error("non-converted item carries measurement data");

endmodule
